### src/hlzm_pkg.sv
// Shared types, codes and reset constants for the Hall limit zone monitor.
// No dependencies; used by every module under src.
package hlzm_pkg;

    // Default widths of the sample and of the age counters
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int AGE_BITS_DEF    = 16;

    // Fixed register widths
    localparam int THR_BITS  = 12;
    localparam int ID_BITS   = 8;
    localparam int IVL_BITS  = 16;
    localparam int CFG_BITS  = 16;
    localparam int IDX_BITS  = 3;
    localparam int ZONE_W    = 16;   // compare width, covers sample widths up to 16 bits

    // Register indexes
    localparam logic [IDX_BITS-1:0] REG_RED_ON      = 3'd0;
    localparam logic [IDX_BITS-1:0] REG_RED_BLINK   = 3'd1;
    localparam logic [IDX_BITS-1:0] REG_GREEN_BLINK = 3'd2;
    localparam logic [IDX_BITS-1:0] REG_GREEN_ON    = 3'd3;
    localparam logic [IDX_BITS-1:0] REG_NODE_ID     = 3'd4;
    localparam logic [IDX_BITS-1:0] REG_HB_TICKS    = 3'd5;
    localparam logic [IDX_BITS-1:0] REG_SMP_TICKS   = 3'd6;
    localparam logic [IDX_BITS-1:0] REG_BLINK_TICKS = 3'd7;

    // Register reset values
    localparam logic [THR_BITS-1:0] RED_ON_RST      = 12'd2160;
    localparam logic [THR_BITS-1:0] RED_BLINK_RST   = 12'd2460;
    localparam logic [THR_BITS-1:0] GREEN_BLINK_RST = 12'd2860;
    localparam logic [THR_BITS-1:0] GREEN_ON_RST    = 12'd3360;
    localparam logic [ID_BITS-1:0]  NODE_ID_RST     = 8'd1;
    localparam logic [IVL_BITS-1:0] HB_TICKS_RST    = 16'd5000;
    localparam logic [IVL_BITS-1:0] SMP_TICKS_RST   = 16'd50;
    localparam logic [IVL_BITS-1:0] BLINK_TICKS_RST = 16'd250;

    // Tick queue depth
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [2:0] {
        KIND_NONE      = 3'd0,
        KIND_HEARTBEAT = 3'd1,
        KIND_MIN       = 3'd2,
        KIND_NEAR_MIN  = 3'd3,
        KIND_NEAR_MAX  = 3'd4,
        KIND_MAX       = 3'd5
    } kind_t;

    typedef enum logic [2:0] {
        ZONE_MIN      = 3'd0,
        ZONE_NEAR_MIN = 3'd1,
        ZONE_NORMAL   = 3'd2,
        ZONE_NEAR_MAX = 3'd3,
        ZONE_MAX      = 3'd4
    } zone_t;

    // One classified tick, handed from front to back
    typedef struct packed {
        logic               hb;
        kind_t              ev;
        logic               red;
        logic               green;
        logic [ID_BITS-1:0] node;
    } tick_rec_t;

    // Zone sort; order of checks decides overlapping thresholds
    function automatic zone_t zone_of(
        input logic [ZONE_W-1:0]   s,
        input logic [THR_BITS-1:0] red_on,
        input logic [THR_BITS-1:0] red_blink,
        input logic [THR_BITS-1:0] green_blink,
        input logic [THR_BITS-1:0] green_on
    );
        zone_t z;
        if (s < ZONE_W'(red_on)) begin
            z = ZONE_MIN;
        end else if (s < ZONE_W'(red_blink)) begin
            z = ZONE_NEAR_MIN;
        end else if (s > ZONE_W'(green_on)) begin
            z = ZONE_MAX;
        end else if (s > ZONE_W'(green_blink)) begin
            z = ZONE_NEAR_MAX;
        end else begin
            z = ZONE_NORMAL;
        end
        return z;
    endfunction

endpackage

### src/hlzm_front.sv
// Front end: configuration registers, tick state, age counters and zone sort.
// Depends on hlzm_pkg; emits one tick record per accepted beat.
module hlzm_front #(
    parameter int SAMPLE_BITS = hlzm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_BITS    = hlzm_pkg::AGE_BITS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [hlzm_pkg::IDX_BITS-1:0]       cfg_index,
    input  logic [hlzm_pkg::CFG_BITS-1:0]       cfg_wdata,
    input  logic                                tick_valid,
    input  logic [SAMPLE_BITS-1:0]              tick_sample,
    output logic                                rec_push,
    output hlzm_pkg::tick_rec_t                 rec_data
);

    localparam int CMP_W = (AGE_BITS > hlzm_pkg::IVL_BITS) ? AGE_BITS : hlzm_pkg::IVL_BITS;

    logic [hlzm_pkg::THR_BITS-1:0] red_on_reg, red_blink_reg, green_blink_reg, green_on_reg;
    logic [hlzm_pkg::ID_BITS-1:0]  node_id_reg;
    logic [hlzm_pkg::IVL_BITS-1:0] hb_ticks_reg, smp_ticks_reg, blink_ticks_reg;

    logic                   started_reg, started_next;
    logic [SAMPLE_BITS-1:0] prev_reg, prev_next;
    logic [AGE_BITS-1:0]    hb_age_reg, hb_age_next;
    logic [AGE_BITS-1:0]    smp_age_reg, smp_age_next;
    logic [AGE_BITS-1:0]    blk_age_reg, blk_age_next;
    logic                   red_reg, red_next;
    logic                   green_reg, green_next;
    logic                   nmin_rep_reg, nmin_rep_next;
    logic                   nmax_rep_reg, nmax_rep_next;

    logic [AGE_BITS-1:0] hb_inc, smp_inc, blk_inc;
    logic                hb_due, smp_due, blk_due;
    hlzm_pkg::zone_t     zn, zp;
    hlzm_pkg::kind_t     ev;
    logic                hb;

    // Saturating increments
    assign hb_inc  = (&hb_age_reg)  ? hb_age_reg  : hb_age_reg  + 1'b1;
    assign smp_inc = (&smp_age_reg) ? smp_age_reg : smp_age_reg + 1'b1;
    assign blk_inc = (&blk_age_reg) ? blk_age_reg : blk_age_reg + 1'b1;

    assign hb_due  = CMP_W'(hb_inc)  >= CMP_W'(hb_ticks_reg);
    assign smp_due = CMP_W'(smp_inc) >= CMP_W'(smp_ticks_reg);
    assign blk_due = CMP_W'(blk_inc) >= CMP_W'(blink_ticks_reg);

    assign zn = hlzm_pkg::zone_of(hlzm_pkg::ZONE_W'(tick_sample), red_on_reg, red_blink_reg,
                                  green_blink_reg, green_on_reg);
    assign zp = hlzm_pkg::zone_of(hlzm_pkg::ZONE_W'(prev_reg), red_on_reg, red_blink_reg,
                                  green_blink_reg, green_on_reg);

    always_comb begin
        started_next  = started_reg;
        prev_next     = prev_reg;
        hb_age_next   = hb_age_reg;
        smp_age_next  = smp_age_reg;
        blk_age_next  = blk_age_reg;
        red_next      = red_reg;
        green_next    = green_reg;
        nmin_rep_next = nmin_rep_reg;
        nmax_rep_next = nmax_rep_reg;
        hb            = 1'b0;
        ev            = hlzm_pkg::KIND_NONE;
        if (!started_reg) begin
            // first tick: latch sample, restart ages, heartbeat
            started_next = 1'b1;
            prev_next    = tick_sample;
            hb_age_next  = '0;
            smp_age_next = '0;
            blk_age_next = '0;
            hb           = 1'b1;
        end else begin
            hb_age_next  = hb_inc;
            smp_age_next = smp_inc;
            blk_age_next = blk_inc;
            if (hb_due) begin
                hb_age_next = '0;
                hb          = 1'b1;
            end
            if (smp_due) begin
                smp_age_next = '0;
                prev_next    = tick_sample;
                if (zn != hlzm_pkg::ZONE_NEAR_MIN) nmin_rep_next = 1'b0;
                if (zn != hlzm_pkg::ZONE_NEAR_MAX) nmax_rep_next = 1'b0;
                unique case (zn)
                    hlzm_pkg::ZONE_MIN: begin
                        if (zp != hlzm_pkg::ZONE_MIN) ev = hlzm_pkg::KIND_MIN;
                        red_next   = 1'b1;
                        green_next = 1'b0;
                    end
                    hlzm_pkg::ZONE_NEAR_MIN: begin
                        if (zp != hlzm_pkg::ZONE_NEAR_MIN && !nmin_rep_reg) begin
                            ev            = hlzm_pkg::KIND_NEAR_MIN;
                            nmin_rep_next = 1'b1;
                        end
                        green_next = 1'b0;
                        if (blk_due) begin
                            blk_age_next = '0;
                            red_next     = !red_reg;
                        end
                    end
                    hlzm_pkg::ZONE_MAX: begin
                        if (zp != hlzm_pkg::ZONE_MAX) ev = hlzm_pkg::KIND_MAX;
                        green_next = 1'b1;
                        red_next   = 1'b0;
                    end
                    hlzm_pkg::ZONE_NEAR_MAX: begin
                        if (zp != hlzm_pkg::ZONE_NEAR_MAX && !nmax_rep_reg) begin
                            ev            = hlzm_pkg::KIND_NEAR_MAX;
                            nmax_rep_next = 1'b1;
                        end
                        red_next = 1'b0;
                        if (blk_due) begin
                            blk_age_next = '0;
                            green_next   = !green_reg;
                        end
                    end
                    default: begin
                        red_next   = 1'b0;
                        green_next = 1'b0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            red_on_reg      <= hlzm_pkg::RED_ON_RST;
            red_blink_reg   <= hlzm_pkg::RED_BLINK_RST;
            green_blink_reg <= hlzm_pkg::GREEN_BLINK_RST;
            green_on_reg    <= hlzm_pkg::GREEN_ON_RST;
            node_id_reg     <= hlzm_pkg::NODE_ID_RST;
            hb_ticks_reg    <= hlzm_pkg::HB_TICKS_RST;
            smp_ticks_reg   <= hlzm_pkg::SMP_TICKS_RST;
            blink_ticks_reg <= hlzm_pkg::BLINK_TICKS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                hlzm_pkg::REG_RED_ON:      red_on_reg      <= cfg_wdata[hlzm_pkg::THR_BITS-1:0];
                hlzm_pkg::REG_RED_BLINK:   red_blink_reg   <= cfg_wdata[hlzm_pkg::THR_BITS-1:0];
                hlzm_pkg::REG_GREEN_BLINK: green_blink_reg <= cfg_wdata[hlzm_pkg::THR_BITS-1:0];
                hlzm_pkg::REG_GREEN_ON:    green_on_reg    <= cfg_wdata[hlzm_pkg::THR_BITS-1:0];
                hlzm_pkg::REG_NODE_ID:     node_id_reg     <= cfg_wdata[hlzm_pkg::ID_BITS-1:0];
                hlzm_pkg::REG_HB_TICKS:    hb_ticks_reg    <= cfg_wdata[hlzm_pkg::IVL_BITS-1:0];
                hlzm_pkg::REG_SMP_TICKS:   smp_ticks_reg   <= cfg_wdata[hlzm_pkg::IVL_BITS-1:0];
                hlzm_pkg::REG_BLINK_TICKS: blink_ticks_reg <= cfg_wdata[hlzm_pkg::IVL_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            started_reg  <= 1'b0;
            prev_reg     <= '0;
            hb_age_reg   <= '0;
            smp_age_reg  <= '0;
            blk_age_reg  <= '0;
            red_reg      <= 1'b0;
            green_reg    <= 1'b0;
            nmin_rep_reg <= 1'b0;
            nmax_rep_reg <= 1'b0;
        end else if (tick_valid) begin
            started_reg  <= started_next;
            prev_reg     <= prev_next;
            hb_age_reg   <= hb_age_next;
            smp_age_reg  <= smp_age_next;
            blk_age_reg  <= blk_age_next;
            red_reg      <= red_next;
            green_reg    <= green_next;
            nmin_rep_reg <= nmin_rep_next;
            nmax_rep_reg <= nmax_rep_next;
        end
    end

    assign rec_push       = tick_valid;
    assign rec_data.hb    = hb;
    assign rec_data.ev    = ev;
    assign rec_data.red   = red_next;
    assign rec_data.green = green_next;
    assign rec_data.node  = node_id_reg;

endmodule

### src/hlzm_queue.sv
// Short FIFO of tick records between front and back.
// Depends on hlzm_pkg for the record type.
module hlzm_queue #(
    parameter int DEPTH = hlzm_pkg::QUEUE_DEPTH
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push,
    input  hlzm_pkg::tick_rec_t push_data,
    input  logic                pop,
    output hlzm_pkg::tick_rec_t head,
    output logic                not_empty,
    output logic                full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    hlzm_pkg::tick_rec_t entry_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                do_push, do_pop;

    assign full      = count_reg == CNT_W'(DEPTH);
    assign not_empty = count_reg != '0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = entry_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (do_push) entry_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

### src/hlzm_back.sv
// Back end: splits each tick record into one or two message beats.
// Depends on hlzm_pkg; drives the registered output channel.
module hlzm_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  hlzm_pkg::tick_rec_t head,
    input  logic                head_valid,
    output logic                pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [15:0]         m_tdata,   // [2:0] msg_kind, [10:3] device_id_out,
                                           // [11] red_led, [12] green_led, [15:13] zero
    output logic                m_tlast    // last_of_tick
);

    logic                          valid_reg;
    logic                          phase_reg;     // heartbeat of a two-beat tick sent
    hlzm_pkg::kind_t               kind_reg, kind_next;
    logic [hlzm_pkg::ID_BITS-1:0]  id_reg;
    logic                          red_reg, green_reg, last_reg;
    logic                          load, split, last_next;

    assign load  = head_valid && (!valid_reg || m_tready);
    assign split = head.hb && head.ev != hlzm_pkg::KIND_NONE && !phase_reg;

    always_comb begin
        last_next = 1'b1;
        if (split) begin
            kind_next = hlzm_pkg::KIND_HEARTBEAT;
            last_next = 1'b0;
        end else if (head.hb && !phase_reg) begin
            kind_next = hlzm_pkg::KIND_HEARTBEAT;
        end else begin
            kind_next = head.ev;
        end
    end

    assign pop = load && last_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            if (load) begin
                valid_reg <= 1'b1;
                phase_reg <= !last_next;
            end else if (m_tready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            kind_reg  <= kind_next;
            id_reg    <= (kind_next == hlzm_pkg::KIND_NONE) ? '0 : head.node;
            red_reg   <= head.red;
            green_reg <= head.green;
            last_reg  <= last_next;
        end
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {3'b000, green_reg, red_reg, id_reg, kind_reg};
    assign m_tlast  = last_reg;

endmodule

### src/hall_limit_zone_monitor_core.sv
// Hall limit zone monitor, top level: front (state, zone sort), tick queue, back (beats).
// Depends on hlzm_pkg, hlzm_front, hlzm_queue and hlzm_back.
// Path: an accepted tick is written into the queue, then loaded into the back end's output register.
// Throughput: one tick per cycle while the queue is not full; a tick with heartbeat plus zone event takes two beats.
// The queue of QUEUE_DEPTH records absorbs two-beat ticks and output stalls.
// Reset: synchronous, active low; registers to defaults, state and queue cleared.
module hall_limit_zone_monitor_core #(
    parameter int SAMPLE_BITS = hlzm_pkg::SAMPLE_BITS_DEF,
    parameter int AGE_BITS    = hlzm_pkg::AGE_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write port
    input  logic                              cfg_wr_en,
    input  logic [hlzm_pkg::IDX_BITS-1:0]     cfg_index,
    input  logic [hlzm_pkg::CFG_BITS-1:0]     cfg_wdata,
    // tick input
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [((SAMPLE_BITS+7)/8)*8-1:0]  s_tdata,   // [SAMPLE_BITS-1:0] sensor_sample
    // message output
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [15:0]                       m_tdata,   // [2:0] msg_kind,
                                                         // [10:3] device_id_out,
                                                         // [11] red_led, [12] green_led
    output logic                              m_tlast    // last_of_tick
);

    logic                rec_push, q_full, q_not_empty, q_pop;
    hlzm_pkg::tick_rec_t rec_data, q_head;
    logic                tick_accept;

    // a beat is taken whenever the queue has a free slot
    assign s_tready    = !q_full;
    assign tick_accept = s_tvalid && s_tready;

    hlzm_front #(
        .SAMPLE_BITS (SAMPLE_BITS),
        .AGE_BITS    (AGE_BITS)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .tick_valid  (tick_accept),
        .tick_sample (s_tdata[SAMPLE_BITS-1:0]),
        .rec_push    (rec_push),
        .rec_data    (rec_data)
    );

    hlzm_queue #(
        .DEPTH (hlzm_pkg::QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (rec_push),
        .push_data (rec_data),
        .pop       (q_pop),
        .head      (q_head),
        .not_empty (q_not_empty),
        .full      (q_full)
    );

    hlzm_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (q_head),
        .head_valid (q_not_empty),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast)
    );

endmodule

### bench/zone_monitor_checker.sv
`timescale 1ns / 100ps
// Message checker for hall_limit_zone_monitor_core: mirrors register writes, predicts the
// beats of every accepted tick and compares them with the message stream. Uses hlzm_pkg.
module zone_monitor_checker (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [hlzm_pkg::IDX_BITS-1:0] cfg_index,
    input  logic [hlzm_pkg::CFG_BITS-1:0] cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [15:0]                   s_tdata,   // [11:0] sensor_sample
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [15:0]                   m_tdata,   // [2:0] kind, [10:3] id, [11] red, [12] green
    input  logic                          m_tlast,
    output int                            fail_count,
    output int                            pending
);

    typedef struct packed {
        hlzm_pkg::kind_t kind;
        logic [7:0]      dev_id;
        logic            red;
        logic            green;
        logic            end_of_tick;
    } msg_t;

    msg_t due_msgs[$];
    msg_t want;

    // register copy
    logic [11:0] red_on_thr, red_blink_thr, green_blink_thr, green_on_thr;
    logic [7:0]  node;
    logic [15:0] hb_ivl, smp_ivl, blink_ivl;

    // monitor state
    logic        running;
    logic [11:0] last_sample;
    logic [15:0] hb_age, smp_age, blink_age;
    logic        red_q, green_q, near_min_seen, near_max_seen;
    int          n_fail = 0;

    function automatic hlzm_pkg::zone_t sort_zone(input logic [11:0] s);
        hlzm_pkg::zone_t z;
        if (s < red_on_thr)
            z = hlzm_pkg::ZONE_MIN;
        else if (s < red_blink_thr)
            z = hlzm_pkg::ZONE_NEAR_MIN;
        else if (s > green_on_thr)
            z = hlzm_pkg::ZONE_MAX;
        else if (s > green_blink_thr)
            z = hlzm_pkg::ZONE_NEAR_MAX;
        else
            z = hlzm_pkg::ZONE_NORMAL;
        return z;
    endfunction

    function automatic logic [15:0] bump(input logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

    // zone evaluation: flags, LEDs, blink; returns the zone event if any
    function automatic hlzm_pkg::kind_t rezone(input logic [11:0] s);
        hlzm_pkg::zone_t zn;
        hlzm_pkg::zone_t zp;
        hlzm_pkg::kind_t ev;
        zn = sort_zone(s);
        zp = sort_zone(last_sample);
        ev = hlzm_pkg::KIND_NONE;
        if (zn != hlzm_pkg::ZONE_NEAR_MIN) near_min_seen = 1'b0;
        if (zn != hlzm_pkg::ZONE_NEAR_MAX) near_max_seen = 1'b0;
        case (zn)
            hlzm_pkg::ZONE_MIN: begin
                if (zp != hlzm_pkg::ZONE_MIN) ev = hlzm_pkg::KIND_MIN;
                red_q   = 1'b1;
                green_q = 1'b0;
            end
            hlzm_pkg::ZONE_NEAR_MIN: begin
                if (zp != hlzm_pkg::ZONE_NEAR_MIN && !near_min_seen) begin
                    ev            = hlzm_pkg::KIND_NEAR_MIN;
                    near_min_seen = 1'b1;
                end
                green_q = 1'b0;
                if (blink_age >= blink_ivl) begin
                    blink_age = '0;
                    red_q     = !red_q;
                end
            end
            hlzm_pkg::ZONE_MAX: begin
                if (zp != hlzm_pkg::ZONE_MAX) ev = hlzm_pkg::KIND_MAX;
                green_q = 1'b1;
                red_q   = 1'b0;
            end
            hlzm_pkg::ZONE_NEAR_MAX: begin
                if (zp != hlzm_pkg::ZONE_NEAR_MAX && !near_max_seen) begin
                    ev            = hlzm_pkg::KIND_NEAR_MAX;
                    near_max_seen = 1'b1;
                end
                red_q = 1'b0;
                if (blink_age >= blink_ivl) begin
                    blink_age = '0;
                    green_q   = !green_q;
                end
            end
            default: begin
                red_q   = 1'b0;
                green_q = 1'b0;
            end
        endcase
        last_sample = s;
        return ev;
    endfunction

    function automatic void predict_tick(input logic [11:0] s);
        hlzm_pkg::kind_t kinds[2];
        hlzm_pkg::kind_t ev;
        int              n;
        msg_t            m;
        n = 0;
        if (!running) begin
            running     = 1'b1;
            last_sample = s;
            hb_age      = '0;
            smp_age     = '0;
            blink_age   = '0;
            kinds[0]    = hlzm_pkg::KIND_HEARTBEAT;
            n           = 1;
        end else begin
            hb_age    = bump(hb_age);
            smp_age   = bump(smp_age);
            blink_age = bump(blink_age);
            if (hb_age >= hb_ivl) begin
                hb_age   = '0;
                kinds[n] = hlzm_pkg::KIND_HEARTBEAT;
                n++;
            end
            if (smp_age >= smp_ivl) begin
                smp_age = '0;
                ev      = rezone(s);
                if (ev != hlzm_pkg::KIND_NONE) begin
                    kinds[n] = ev;
                    n++;
                end
            end
            if (n == 0) begin
                kinds[0] = hlzm_pkg::KIND_NONE;
                n        = 1;
            end
        end
        for (int k = 0; k < n; k++) begin
            m.kind        = kinds[k];
            m.dev_id      = (kinds[k] == hlzm_pkg::KIND_NONE) ? 8'd0 : node;
            m.red         = red_q;
            m.green       = green_q;
            m.end_of_tick = (k == n - 1);
            due_msgs.push_back(m);
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            red_on_thr      = hlzm_pkg::RED_ON_RST;
            red_blink_thr   = hlzm_pkg::RED_BLINK_RST;
            green_blink_thr = hlzm_pkg::GREEN_BLINK_RST;
            green_on_thr    = hlzm_pkg::GREEN_ON_RST;
            node            = hlzm_pkg::NODE_ID_RST;
            hb_ivl          = hlzm_pkg::HB_TICKS_RST;
            smp_ivl         = hlzm_pkg::SMP_TICKS_RST;
            blink_ivl       = hlzm_pkg::BLINK_TICKS_RST;
            running         = 1'b0;
            last_sample     = '0;
            hb_age          = '0;
            smp_age         = '0;
            blink_age       = '0;
            red_q           = 1'b0;
            green_q         = 1'b0;
            near_min_seen   = 1'b0;
            near_max_seen   = 1'b0;
            due_msgs.delete();
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    hlzm_pkg::REG_RED_ON:      red_on_thr      = cfg_wdata[11:0];
                    hlzm_pkg::REG_RED_BLINK:   red_blink_thr   = cfg_wdata[11:0];
                    hlzm_pkg::REG_GREEN_BLINK: green_blink_thr = cfg_wdata[11:0];
                    hlzm_pkg::REG_GREEN_ON:    green_on_thr    = cfg_wdata[11:0];
                    hlzm_pkg::REG_NODE_ID:     node            = cfg_wdata[7:0];
                    hlzm_pkg::REG_HB_TICKS:    hb_ivl          = cfg_wdata;
                    hlzm_pkg::REG_SMP_TICKS:   smp_ivl         = cfg_wdata;
                    hlzm_pkg::REG_BLINK_TICKS: blink_ivl       = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                predict_tick(s_tdata[11:0]);
            if (m_tvalid && m_tready) begin
                if (due_msgs.size() == 0) begin
                    $error("unexpected message beat: tdata=%h tlast=%b", m_tdata, m_tlast);
                    n_fail++;
                end else begin
                    want = due_msgs.pop_front();
                    if (m_tdata[2:0] != want.kind) begin
                        $error("msg_kind: expected %0d, got %0d", want.kind, m_tdata[2:0]);
                        n_fail++;
                    end
                    if (m_tdata[10:3] != want.dev_id) begin
                        $error("device_id_out: expected %0d, got %0d",
                               want.dev_id, m_tdata[10:3]);
                        n_fail++;
                    end
                    if (m_tdata[11] != want.red) begin
                        $error("red_led: expected %0d, got %0d", want.red, m_tdata[11]);
                        n_fail++;
                    end
                    if (m_tdata[12] != want.green) begin
                        $error("green_led: expected %0d, got %0d", want.green, m_tdata[12]);
                        n_fail++;
                    end
                    if (m_tlast != want.end_of_tick) begin
                        $error("last_of_tick: expected %0d, got %0d", want.end_of_tick, m_tlast);
                        n_fail++;
                    end
                end
            end
        end
        fail_count <= n_fail;
        pending    <= due_msgs.size();
    end

endmodule

### bench/tb_top.sv
`timescale 1ns / 100ps
// Testbench top for hall_limit_zone_monitor_core: clock, reset, ticks, register writes,
// message back-pressure and the verdict. Depends on hlzm_pkg, the core and zone_monitor_checker.
module tb_top;

    localparam int IDLE_MAX        = 14;
    localparam int DRAIN_CYCLES    = 8;     // extra margin after the last predicted beat
    localparam int RAND_PHASES     = 10;
    localparam int TICKS_PER_PHASE = 110;

    logic                          aclk      = 1'b0;
    logic                          aresetn   = 1'b0;
    logic                          cfg_wr_en = 1'b0;
    logic [hlzm_pkg::IDX_BITS-1:0] cfg_index = '0;
    logic [hlzm_pkg::CFG_BITS-1:0] cfg_wdata = '0;
    logic                          s_tvalid  = 1'b0;
    logic                          s_tready;
    logic [15:0]                   s_tdata   = '0;     // [11:0] sensor_sample
    logic                          m_tvalid;
    logic                          m_tready  = 1'b0;
    logic [15:0]                   m_tdata;    // [2:0] kind, [10:3] id, [11] red, [12] green
    logic                          m_tlast;    // last_of_tick

    int fail_count;
    int pending;

    // per-phase switches for gaps on either side
    bit send_idle = 1'b1;
    bit recv_idle = 1'b1;

    // thresholds in force, used to aim samples at zone edges
    logic [11:0] thr [4];
    logic [11:0] prev_s = '0;

    // directed samples against the reset thresholds (2160 / 2460 / 2860 / 3360):
    // limit and near entries, repeats held by the reported flag, every boundary value
    logic [11:0] dir_list [0:19] = '{
        12'd0,    12'd0,    12'd2300, 12'd2300, 12'd2700,
        12'd3000, 12'd3000, 12'd4095, 12'd4095, 12'd2200,
        12'd2159, 12'd2160, 12'd2459, 12'd2460, 12'd2860,
        12'd2861, 12'd3360, 12'd3361, 12'd0,    12'd4095
    };

    // zero intervals: heartbeat, evaluation and blink due on every tick;
    // ends in near-min so the reported flag is set for the hold-off check
    logic [11:0] zero_ivl_list [0:5] = '{
        12'd2300, 12'd3000, 12'd100, 12'd4000, 12'd2300, 12'd2300
    };

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    hall_limit_zone_monitor_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    zone_monitor_checker u_check (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_index  (cfg_index),
        .cfg_wdata  (cfg_wdata),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // one register write per cycle; wr_en stays high across a burst and is
    // dropped by the caller
    task automatic write_reg(input logic [hlzm_pkg::IDX_BITS-1:0] idx,
                             input logic [hlzm_pkg::CFG_BITS-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
    endtask

    // full register set; junk above each register's width must be dropped by the core
    task automatic load_settings(input logic [11:0] t0, input logic [11:0] t1,
                                 input logic [11:0] t2, input logic [11:0] t3,
                                 input logic [7:0] id, input logic [15:0] hb,
                                 input logic [15:0] smp, input logic [15:0] blk);
        write_reg(hlzm_pkg::REG_RED_ON,      {4'($urandom), t0});
        write_reg(hlzm_pkg::REG_RED_BLINK,   {4'($urandom), t1});
        write_reg(hlzm_pkg::REG_GREEN_BLINK, {4'($urandom), t2});
        write_reg(hlzm_pkg::REG_GREEN_ON,    {4'($urandom), t3});
        write_reg(hlzm_pkg::REG_NODE_ID,     {8'($urandom), id});
        write_reg(hlzm_pkg::REG_HB_TICKS,    hb);
        write_reg(hlzm_pkg::REG_SMP_TICKS,   smp);
        write_reg(hlzm_pkg::REG_BLINK_TICKS, blk);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        thr[0] = t0;
        thr[1] = t1;
        thr[2] = t2;
        thr[3] = t3;
    endtask

    // tvalid is left high after the beat so back-to-back ticks need no re-raise
    task automatic send_tick(input logic [11:0] s);
        int gap;
        gap = send_idle ? $urandom_range(0, IDLE_MAX) : 0;
        repeat (gap) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= {4'd0, s};
        do @(posedge aclk); while (!s_tready);
        prev_s = s;
    endtask

    // stop the stream and wait for every predicted beat before touching registers
    task automatic settle();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    // mostly samples near a threshold or repeats of the last one (keeps a zone so
    // the LEDs blink), plus full-range values and the rails
    function automatic logic [11:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0, 1:       v = $urandom_range(0, 4095);
            2, 3, 4, 5: v = int'(thr[$urandom_range(0, 3)]) + int'($urandom_range(0, 8)) - 4;
            6, 7:       v = int'(prev_s);
            8:          v = 0;
            default:    v = 4095;
        endcase
        if (v < 0)    v = 0;
        if (v > 4095) v = 4095;
        return v[11:0];
    endfunction

    task automatic run_ticks(input int n);
        repeat (n) send_tick(pick_sample());
    endtask

    // random register set; every fourth phase leaves the thresholds unordered
    task automatic random_settings(input int p);
        int t0, t1, t2, t3;
        if (p % 4 == 3) begin
            t0 = $urandom_range(0, 4095);
            t1 = $urandom_range(0, 4095);
            t2 = $urandom_range(0, 4095);
            t3 = $urandom_range(0, 4095);
        end else begin
            t0 = $urandom_range(0, 3000);
            t1 = t0 + $urandom_range(0, 300);
            t2 = t1 + $urandom_range(0, 400);
            t3 = t2 + $urandom_range(0, 500);
            if (t3 > 4095) t3 = 4095;
            if (t2 > 4095) t2 = 4095;
        end
        load_settings(t0[11:0], t1[11:0], t2[11:0], t3[11:0], 8'($urandom),
                      16'($urandom_range(1, 24)),
                      16'(($urandom_range(0, 3) == 0) ? $urandom_range(4, 12)
                                                      : $urandom_range(1, 3)),
                      16'($urandom_range(1, 6)));
    endtask

    // message side: random stall before each beat, none in quiet phases
    initial begin
        int stall;
        forever begin
            stall = recv_idle ? $urandom_range(0, IDLE_MAX) : 0;
            repeat (stall) begin
                @(negedge aclk);
                m_tready <= 1'b0;
            end
            @(negedge aclk);
            m_tready <= 1'b1;
            do @(posedge aclk); while (!(m_tvalid && m_tready));
        end
    end

    initial begin
        thr[0] = hlzm_pkg::RED_ON_RST;
        thr[1] = hlzm_pkg::RED_BLINK_RST;
        thr[2] = hlzm_pkg::GREEN_BLINK_RST;
        thr[3] = hlzm_pkg::GREEN_ON_RST;

        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // reset register values; first tick must give the start-up heartbeat,
        // one evaluation falls in at the 50th tick after it
        run_ticks(60);
        settle();

        // directed zone walk, evaluation every tick, fast heartbeat and blink
        send_idle = 1'b0;
        recv_idle = 1'b1;
        load_settings(hlzm_pkg::RED_ON_RST, hlzm_pkg::RED_BLINK_RST,
                      hlzm_pkg::GREEN_BLINK_RST, hlzm_pkg::GREEN_ON_RST,
                      8'hA5, 16'd4, 16'd1, 16'd2);
        foreach (dir_list[i]) send_tick(dir_list[i]);
        settle();

        send_idle = 1'b1;
        load_settings(hlzm_pkg::RED_ON_RST, hlzm_pkg::RED_BLINK_RST,
                      hlzm_pkg::GREEN_BLINK_RST, hlzm_pkg::GREEN_ON_RST,
                      8'd255, 16'd0, 16'd0, 16'd0);
        foreach (zero_ivl_list[i]) send_tick(zero_ivl_list[i]);
        settle();

        // move the min edge above the stored sample: previous zone becomes min while
        // the near-min flag is still set, so the near-min event stays held off
        write_reg(hlzm_pkg::REG_RED_ON, 16'd2350);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        thr[0] = 12'd2350;
        send_tick(12'd2400);
        settle();

        // register extremes: everything normal, then everything min/max
        send_idle = 1'b0;
        recv_idle = 1'b0;
        load_settings(12'd0, 12'd0, 12'd4095, 12'd4095, 8'd0, 16'hFFFF, 16'd1, 16'hFFFF);
        run_ticks(60);
        settle();
        send_idle = 1'b1;
        recv_idle = 1'b1;
        load_settings(12'd4095, 12'd4095, 12'd0, 12'd0, 8'd255, 16'd1, 16'hFFFF, 16'd1);
        run_ticks(60);
        settle();

        for (int p = 0; p < RAND_PHASES; p++) begin
            send_idle = ($urandom_range(0, 2) != 0);
            recv_idle = ($urandom_range(0, 2) != 0);
            random_settings(p);
            run_ticks(TICKS_PER_PHASE);
            settle();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

    // hang guard, several times the slowest legal run
    initial begin
        #5_000_000;
        $display("== FAIL ==");
        $finish;
    end

endmodule

### sim.f
src/hlzm_pkg.sv
src/hlzm_front.sv
src/hlzm_queue.sv
src/hlzm_back.sv
src/hall_limit_zone_monitor_core.sv
bench/zone_monitor_checker.sv
bench/tb_top.sv
